### rtl/pfr_pkg.sv
`default_nettype none

package pfr_pkg;

   // Table geometry; the slot and config field widths follow from the frame count
   localparam int NUM_FRAMES = 16;
   localparam int PAGE_BITS = 16;
   localparam int SLOT_BITS = $clog2(NUM_FRAMES);
   localparam int FRAMES_CFG_BITS = SLOT_BITS + 1;
   localparam int COUNT_BITS = 16;

   // Stream and register port widths
   localparam int REQ_TDATA_BITS = 24;
   localparam int RSP_TDATA_BITS = 56;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = FRAMES_CFG_BITS;

   localparam logic [FRAMES_CFG_BITS-1:0] FRAMES_CFG_RESET = FRAMES_CFG_BITS'(NUM_FRAMES);

   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic {
      POLICY_FIFO = 1'b0,
      POLICY_LRU  = 1'b1
   } policy_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAMES_IN_USE = 1'b0,
      CSR_POLICY        = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FRAMES_CFG_BITS-1:0] frames_in_use;
      policy_type                 policy;
   } cfg_type;

   typedef struct packed {
      page_type page;
      logic     start_of_sequence;
   } req_item_type;

   typedef struct packed {
      logic      hit;
      slot_type  slot;
      logic      evicted_valid;
      page_type  evicted_page;
      count_type hit_total;
      count_type miss_total;
   } rsp_item_type;

endpackage

`default_nettype wire

### rtl/pfr_core.sv
`default_nettype none

module pfr_core import pfr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_item_type item,
   input  wire cfg_type      cfg,
   output rsp_item_type      result
);

   localparam int KEY_BITS = SLOT_BITS + 1;

   // Frame table state
   page_type                frame_page_ff [NUM_FRAMES];
   logic [NUM_FRAMES-1:0]   frame_valid_ff, frame_valid_in;
   slot_type                rank_ff [NUM_FRAMES];
   slot_type                rank_in [NUM_FRAMES];
   slot_type                rr_ptr_ff, rr_ptr_in;
   count_type               hit_count_ff, hit_count_in;
   count_type               miss_count_ff, miss_count_in;

   // Working values
   logic [FRAMES_CFG_BITS-1:0] n_active;
   logic [NUM_FRAMES-1:0]      active;
   logic [NUM_FRAMES-1:0]      valid_eff;
   slot_type                   rank_eff [NUM_FRAMES];
   slot_type                   ptr_eff;
   count_type                  hit_eff, miss_eff;
   logic [NUM_FRAMES-1:0]      match, empty;
   logic                       hit, has_empty;
   slot_type                   hit_slot, empty_slot, fifo_slot, slot;
   logic [FRAMES_CFG_BITS-1:0] fifo_next;
   logic                       slot_valid;
   logic [KEY_BITS-1:0]        old_rank;
   logic [KEY_BITS-1:0]        key_l [SLOT_BITS+1][NUM_FRAMES];
   slot_type                   idx_l [SLOT_BITS+1][NUM_FRAMES];

   // Active frame count, clamped to 1..NUM_FRAMES
   always_comb begin
      if (cfg.frames_in_use == '0) begin
         n_active = FRAMES_CFG_BITS'(1);
      end else if (cfg.frames_in_use > FRAMES_CFG_BITS'(NUM_FRAMES)) begin
         n_active = FRAMES_CFG_BITS'(NUM_FRAMES);
      end else begin
         n_active = cfg.frames_in_use;
      end
   end

   // State as seen by this beat: a start flag empties everything first
   always_comb begin
      for (int j = 0; j < NUM_FRAMES; j++) begin
         active[j]   = FRAMES_CFG_BITS'(j) < n_active;
         valid_eff[j] = item.start_of_sequence ? 1'b0 : frame_valid_ff[j];
         rank_eff[j] = item.start_of_sequence ? '0 : rank_ff[j];
         match[j]    = active[j] && valid_eff[j] && (frame_page_ff[j] == item.page);
         empty[j]    = active[j] && !valid_eff[j];
      end
      ptr_eff  = item.start_of_sequence ? '0 : rr_ptr_ff;
      hit_eff  = item.start_of_sequence ? '0 : hit_count_ff;
      miss_eff = item.start_of_sequence ? '0 : miss_count_ff;
   end

   // Lowest matching frame and lowest empty frame
   always_comb begin
      hit_slot   = '0;
      empty_slot = '0;
      for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
         if (match[j]) begin
            hit_slot = SLOT_BITS'(j);
         end
         if (empty[j]) begin
            empty_slot = SLOT_BITS'(j);
         end
      end
      hit       = |match;
      has_empty = |empty;
   end

   // Oldest frame: max-rank tree, inactive frames lose, the left side wins a tie
   always_comb begin
      for (int l = 0; l <= SLOT_BITS; l++) begin
         for (int j = 0; j < NUM_FRAMES; j++) begin
            key_l[l][j] = '0;
            idx_l[l][j] = '0;
         end
      end
      for (int j = 0; j < NUM_FRAMES; j++) begin
         key_l[0][j] = {active[j], rank_eff[j]};
         idx_l[0][j] = SLOT_BITS'(j);
      end
      for (int l = 1; l <= SLOT_BITS; l++) begin
         for (int j = 0; j < NUM_FRAMES / 2; j++) begin
            if (j < (NUM_FRAMES >> l)) begin
               if (key_l[l-1][2*j+1] > key_l[l-1][2*j]) begin
                  key_l[l][j] = key_l[l-1][2*j+1];
                  idx_l[l][j] = idx_l[l-1][2*j+1];
               end else begin
                  key_l[l][j] = key_l[l-1][2*j];
                  idx_l[l][j] = idx_l[l-1][2*j];
               end
            end
         end
      end
   end

   // Round-robin victim, wrapped into the active range
   always_comb begin
      if ({1'b0, ptr_eff} >= n_active) begin
         fifo_slot = '0;
      end else begin
         fifo_slot = ptr_eff;
      end
      if ({1'b0, fifo_slot} + FRAMES_CFG_BITS'(1) >= n_active) begin
         fifo_next = '0;
      end else begin
         fifo_next = {1'b0, fifo_slot} + FRAMES_CFG_BITS'(1);
      end
   end

   // Slot choice and next state
   always_comb begin
      if (hit) begin
         slot = hit_slot;
      end else if (cfg.policy == POLICY_FIFO) begin
         slot = fifo_slot;
      end else if (has_empty) begin
         slot = empty_slot;
      end else begin
         slot = idx_l[SLOT_BITS][0];
      end
      slot_valid = valid_eff[slot];
      old_rank   = slot_valid ? {1'b0, rank_eff[slot]} : KEY_BITS'(NUM_FRAMES);

      frame_valid_in       = valid_eff;
      frame_valid_in[slot] = 1'b1;
      for (int j = 0; j < NUM_FRAMES; j++) begin
         rank_in[j] = rank_eff[j];
         if (active[j] && valid_eff[j] && ({1'b0, rank_eff[j]} < old_rank)
             && (rank_eff[j] != SLOT_BITS'(NUM_FRAMES - 1))) begin
            rank_in[j] = rank_eff[j] + SLOT_BITS'(1);
         end
      end
      rank_in[slot] = '0;

      rr_ptr_in     = ptr_eff;
      hit_count_in  = hit_eff;
      miss_count_in = miss_eff;
      if (hit) begin
         if (hit_eff != '1) begin
            hit_count_in = hit_eff + COUNT_BITS'(1);
         end
      end else begin
         if (cfg.policy == POLICY_FIFO) begin
            rr_ptr_in = fifo_next[SLOT_BITS-1:0];
         end
         if (miss_eff != '1) begin
            miss_count_in = miss_eff + COUNT_BITS'(1);
         end
      end

      result.hit           = hit;
      result.slot          = slot;
      result.evicted_valid = !hit && slot_valid;
      result.evicted_page  = (!hit && slot_valid) ? frame_page_ff[slot] : '0;
      result.hit_total     = hit_count_in;
      result.miss_total    = miss_count_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         rr_ptr_ff      <= '0;
         hit_count_ff   <= '0;
         miss_count_ff  <= '0;
         for (int j = 0; j < NUM_FRAMES; j++) begin
            rank_ff[j] <= '0;
         end
      end else if (step) begin
         frame_valid_ff <= frame_valid_in;
         rr_ptr_ff      <= rr_ptr_in;
         hit_count_ff   <= hit_count_in;
         miss_count_ff  <= miss_count_in;
         for (int j = 0; j < NUM_FRAMES; j++) begin
            rank_ff[j] <= rank_in[j];
         end
      end
   end

   // Page store, no reset: only read where the valid bit is set
   always_ff @(posedge clock) begin
      if (step) begin
         frame_page_ff[slot] <= item.page;
      end
   end

   // The used frame is always resident afterwards
   a_slot_resident: assert property (@(posedge clock) disable iff (reset)
      step |=> frame_valid_ff[$past(slot)])
      else $error("used frame not valid after step");

   // A hit never reports an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (step && hit) |-> !result.evicted_valid)
      else $error("eviction reported on a hit");

   // Hit total only falls on a sequence start
   a_hit_monotonic: assert property (@(posedge clock) disable iff (reset)
      (step && !item.start_of_sequence) |=> (hit_count_ff >= $past(hit_count_ff)))
      else $error("hit total decreased without start");

   // Used frame gets the top recency rank
   a_used_rank: assert property (@(posedge clock) disable iff (reset)
      step |=> (rank_ff[$past(slot)] == '0))
      else $error("used frame not most recent");

endmodule

`default_nettype wire

### rtl/page_frame_replacement_unit.sv
`default_nettype none

// Page frame replacement unit. Each req beat is one page reference, looked up in a
// fully associative table of 16 frames (first csr frames_in_use of them active);
// the rsp beat reports hit, slot, evicted page and saturating hit/miss totals, with
// FIFO or LRU replacement chosen by the policy register. One reference per clock
// is sustained while rsp_tready is high: lookup, victim choice and table update
// are combinational between the request register and the response register, so
// each result is registered when its reference leaves the request register, and
// the next reference sees the table left by the previous one. Configuration must
// only be written while no reference is in flight.
module page_frame_replacement_unit import pfr_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // req_tdata: page[15:0], start_of_sequence[16], zero pad[23:17]
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_TDATA_BITS-1:0] req_tdata,
   // rsp_tdata: hit[0], slot[4:1], evicted_valid[5], evicted_page[21:6],
   //            hit_total[37:22], miss_total[53:38], zero pad[55:54]
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0]      rsp_tdata,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int RSP_USED_BITS = 1 + SLOT_BITS + 1 + PAGE_BITS + 2 * COUNT_BITS;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   cfg_type      cfg_ff;
   logic         advance;
   rsp_item_type result;

   // Work advances when the response register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.page              <= req_tdata[PAGE_BITS-1:0];
         in_item_ff.start_of_sequence <= req_tdata[PAGE_BITS];
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frames_in_use <= FRAMES_CFG_RESET;
         cfg_ff.policy        <= POLICY_FIFO;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FRAMES_IN_USE: begin
               cfg_ff.frames_in_use <= csr_data[FRAMES_CFG_BITS-1:0];
            end
            CSR_POLICY: begin
               cfg_ff.policy <= policy_type'(csr_data[0]);
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   pfr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - RSP_USED_BITS){1'b0}},
                        out_item_ff.miss_total,
                        out_item_ff.hit_total,
                        out_item_ff.evicted_page,
                        out_item_ff.evicted_valid,
                        out_item_ff.slot,
                        out_item_ff.hit};

endmodule

`default_nettype wire
